FILE: src/ppfc_pkg.sv
// Package for the palette pixel format converter.
// Holds the shared types, codes and the pixel conversion function; no dependencies.
package ppfc_pkg;

  localparam int unsigned IdxW   = 8;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned CountW = 9;
  localparam int unsigned OpW    = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 9;

  localparam logic [ChanW-1:0] ChanMax = 8'hFF;

  localparam logic [CfgIdxW-1:0] CFG_SRC_FMT   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DST_FMT   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PAL_COUNT = 2'd2;

  typedef enum logic [OpW-1:0] {
    OP_PIXEL     = 3'd0,
    OP_WR_ENTRY  = 3'd1,
    OP_WR_COLOR  = 3'd2,
    OP_WR_ALPHA  = 3'd3,
    OP_GREY_FILL = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    SRC_INDEXED = 2'd0,
    SRC_RGB24   = 2'd1,
    SRC_RGBA32  = 2'd2
  } src_fmt_e;

  typedef enum logic {
    DST_RGB24  = 1'b0,
    DST_RGBA32 = 1'b1
  } dst_fmt_e;

  typedef enum logic [1:0] {
    FILL_IDLE  = 2'd0,
    FILL_DIV   = 2'd1,
    FILL_WRITE = 2'd2
  } fill_state_e;

  typedef struct packed {
    logic [ChanW-1:0] alpha;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } entry_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] addr;
    entry_t          data;
  } wr_t;

  // Brings the pixel into four-byte terms, then emits it in the destination format.
  function automatic entry_t convert_pixel(logic [1:0] src, logic dst, logic in_range,
                                           entry_t lookup, entry_t pix);
    entry_t p;
    entry_t res;
    logic   four_byte;
    p         = pix;
    four_byte = 1'b1;
    if (src == SRC_INDEXED) begin
      p = in_range ? lookup : '0;
    end else if (src == SRC_RGB24) begin
      p.alpha   = '0;
      four_byte = 1'b0;
    end
    res.green = p.green;
    if (dst == DST_RGBA32) begin
      res.red   = four_byte ? p.red : p.blue;
      res.blue  = four_byte ? p.blue : p.red;
      res.alpha = four_byte ? p.alpha : ChanMax;
    end else begin
      res.red   = four_byte ? p.blue : p.red;
      res.blue  = four_byte ? p.red : p.blue;
      res.alpha = '0;
    end
    return res;
  endfunction

endpackage

FILE: src/ppfc_palette_ram.sv
// Palette memory: one write port and one registered read port.
// Depends on ppfc_pkg for the entry and write types.
module ppfc_palette_ram #(
  parameter int unsigned Depth = 256
) (
  input  logic                   clk_i,
  input  logic                   re_i,
  input  logic [ppfc_pkg::IdxW-1:0] raddr_i,
  output ppfc_pkg::entry_t       rdata_o,
  input  ppfc_pkg::wr_t          wr_i
);
  import ppfc_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  entry_t mem [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr[AddrW-1:0]] <= wr_i.data;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i[AddrW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/ppfc_grey_gen.sv
// Grey ramp generator: for two or more entries one serial divide of 255 by count-1, then one palette write per cycle.
// Depends on ppfc_pkg for the write type and the state enum.
module ppfc_grey_gen (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ppfc_pkg::CountW-1:0] count_i,
  output logic                        busy_o,
  output ppfc_pkg::wr_t               wr_o
);
  import ppfc_pkg::*;

  fill_state_e       state_q, state_d;
  logic [CountW-1:0] cnt_q;
  logic [ChanW-1:0]  div_q, rem_q, quo_q, val_q, acc_q;
  logic [IdxW-1:0]   pos_q;
  logic [2:0]        step_q;
  logic [ChanW:0]    shifted, acc_sum;
  logic              div_ge, acc_ge, last_pos;

  assign shifted  = {rem_q, 1'b1};
  assign div_ge   = shifted >= {1'b0, div_q};
  assign acc_sum  = {1'b0, acc_q} + {1'b0, rem_q};
  assign acc_ge   = (div_q != '0) && (acc_sum >= {1'b0, div_q});
  assign last_pos = ({1'b0, pos_q} + 9'd1) == cnt_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FILL_IDLE: begin
        if (start_i) begin
          if (count_i > 9'd1) begin
            state_d = FILL_DIV;
          end else if (count_i == 9'd1) begin
            state_d = FILL_WRITE;
          end
        end
      end
      FILL_DIV: begin
        if (step_q == 3'd7) begin
          state_d = FILL_WRITE;
        end
      end
      FILL_WRITE: begin
        if (last_pos) begin
          state_d = FILL_IDLE;
        end
      end
      default: state_d = FILL_IDLE;
    endcase
  end

  always_comb begin
    busy_o       = state_q != FILL_IDLE;
    wr_o.we      = state_q == FILL_WRITE;
    wr_o.addr    = pos_q;
    wr_o.data    = '{alpha: ChanMax, red: val_q, green: val_q, blue: val_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FILL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      FILL_IDLE: begin
        cnt_q  <= count_i;
        div_q  <= 8'(count_i - 9'd1);
        rem_q  <= '0;
        quo_q  <= '0;
        step_q <= '0;
        pos_q  <= '0;
        val_q  <= '0;
        acc_q  <= '0;
      end
      FILL_DIV: begin
        rem_q  <= div_ge ? 8'(shifted - {1'b0, div_q}) : shifted[ChanW-1:0];
        quo_q  <= {quo_q[ChanW-2:0], div_ge};
        step_q <= step_q + 3'd1;
      end
      FILL_WRITE: begin
        acc_q <= acc_ge ? 8'(acc_sum - {1'b0, div_q}) : acc_sum[ChanW-1:0];
        val_q <= val_q + quo_q + {7'd0, acc_ge};
        pos_q <= pos_q + 8'd1;
      end
      default: begin
        step_q <= '0;
      end
    endcase
  end

endmodule

FILE: src/palette_pixel_format_converter.sv
// Palette pixel format converter, top level.
// A result word is registered in stage 1, with the palette read, and then in the output register.
// Throughput: one word per cycle while the output drains; with two or more entries a grey fill
// stalls the input while it launches, runs a serial divide of 8 steps, then writes each entry.
// Reset: handshakes and fill control clear, registers take their reset values, and the palette
// memory holds no defined content until written. Uses ppfc_pkg.
module palette_pixel_format_converter #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [ppfc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ppfc_pkg::CfgDataW-1:0] cfg_data_i,
  // Input word stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: entry_index, in_red, in_green, in_blue, in_alpha (lowest bits first).
  input  logic [39:0] s_axis_tdata,
  // tuser: opcode.
  input  logic [ppfc_pkg::OpW-1:0] s_axis_tuser,
  // Result word stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: out_red, out_green, out_blue, out_alpha (lowest bits first).
  output logic [31:0] m_axis_tdata
);
  import ppfc_pkg::*;

  localparam logic [CountW-1:0] DepthCnt = CountW'(PALETTE_DEPTH);

  logic [1:0]        src_fmt_q;
  logic              dst_fmt_q;
  logic [CountW-1:0] pal_count_q, eff_count;

  logic              s1_valid_q, s1_in_range_q;
  logic [OpW-1:0]    s1_op_q;
  logic [IdxW-1:0]   s1_idx_q;
  entry_t            s1_pix_q;

  logic              fwd_valid_q;
  logic [IdxW-1:0]   fwd_addr_q;
  entry_t            fwd_data_q;

  logic              out_valid_q;
  entry_t            out_data_q;

  logic              accept, s1_adv, out_free, fill_start, fill_busy;
  logic              s1_is_wr;
  entry_t            rdata, lookup;
  wr_t               s1_wr, fill_wr, mem_wr;
  logic [IdxW-1:0]   in_idx;
  entry_t            in_pix;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_fmt_q   <= SRC_INDEXED;
      dst_fmt_q   <= DST_RGBA32;
      pal_count_q <= 9'd256;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_SRC_FMT) begin
        src_fmt_q <= cfg_data_i[1:0];
      end else if (cfg_index_i == CFG_DST_FMT) begin
        dst_fmt_q <= cfg_data_i[0];
      end else if (cfg_index_i == CFG_PAL_COUNT) begin
        pal_count_q <= cfg_data_i;
      end
    end
  end

  assign eff_count = (pal_count_q < DepthCnt) ? pal_count_q : DepthCnt;

  assign in_idx       = s_axis_tdata[7:0];
  assign in_pix.red   = s_axis_tdata[15:8];
  assign in_pix.green = s_axis_tdata[23:16];
  assign in_pix.blue  = s_axis_tdata[31:24];
  assign in_pix.alpha = s_axis_tdata[39:32];

  assign out_free   = !out_valid_q || m_axis_tready;
  assign s1_adv     = s1_valid_q && ((s1_op_q != OP_PIXEL) || out_free);
  assign fill_start = s1_adv && (s1_op_q == OP_GREY_FILL);
  assign s_axis_tready = !fill_busy && !(s1_valid_q && (s1_op_q == OP_GREY_FILL))
                         && (!s1_valid_q || s1_adv);
  assign accept     = s_axis_tvalid && s_axis_tready;

  ppfc_palette_ram #(
    .Depth(PALETTE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .re_i   (accept),
    .raddr_i(in_idx),
    .rdata_o(rdata),
    .wr_i   (mem_wr)
  );

  ppfc_grey_gen u_grey (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(fill_start),
    .count_i(eff_count),
    .busy_o (fill_busy),
    .wr_o   (fill_wr)
  );

  // The read issued in the same cycle as a write to that entry returns stale data, so the last write is forwarded.
  assign lookup = (fwd_valid_q && (fwd_addr_q == s1_idx_q)) ? fwd_data_q : rdata;

  assign s1_is_wr = (s1_op_q == OP_WR_ENTRY) || (s1_op_q == OP_WR_COLOR)
                    || (s1_op_q == OP_WR_ALPHA);

  always_comb begin
    s1_wr.we   = s1_adv && s1_is_wr && s1_in_range_q;
    s1_wr.addr = s1_idx_q;
    s1_wr.data = s1_pix_q;
    if (s1_op_q == OP_WR_COLOR) begin
      s1_wr.data.alpha = ChanMax;
    end else if (s1_op_q == OP_WR_ALPHA) begin
      s1_wr.data       = lookup;
      s1_wr.data.alpha = s1_pix_q.alpha;
    end
  end

  assign mem_wr = fill_busy ? fill_wr : s1_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (mem_wr.we) begin
        fwd_valid_q <= 1'b1;
      end
      if (s1_adv && (s1_op_q == OP_PIXEL)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q       <= s_axis_tuser;
      s1_idx_q      <= in_idx;
      s1_pix_q      <= in_pix;
      s1_in_range_q <= {1'b0, in_idx} < eff_count;
    end
    if (mem_wr.we) begin
      fwd_addr_q <= mem_wr.addr;
      fwd_data_q <= mem_wr.data;
    end
    if (s1_adv && (s1_op_q == OP_PIXEL)) begin
      out_data_q <= convert_pixel(src_fmt_q, dst_fmt_q, s1_in_range_q, lookup, s1_pix_q);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_data_q.alpha, out_data_q.blue, out_data_q.green, out_data_q.red};

  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fill_wr.we && s1_wr.we))
    else $error("grey fill and item write hit the palette in the same cycle");

  a_fill_drains_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fill_busy) |-> !s1_valid_q)
    else $error("grey fill started with an item still in flight");

  a_no_accept_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_start |=> !$past(accept))
    else $error("word accepted while a grey fill was being launched");

endmodule

FILE: sim/palette_pixel_checker.sv
`timescale 1ns / 1ps
// Checker for the palette pixel format converter: watches the register, input and result
// channels, keeps its own color table and predicts each result word. Uses ppfc_pkg.
module palette_pixel_checker
  import ppfc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [39:0]         in_data_i,
  input  logic [OpW-1:0]      in_user_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [31:0]         out_data_i,
  output int                  pending_o,
  output int                  mismatches_o
);

  entry_t              color_table [256];
  entry_t              pixels_due [$];
  logic [1:0]          src_mode;
  logic                dst_mode;
  logic [CountW-1:0]   entries_set;
  int                  mismatch_count = 0;

  function automatic int unsigned entries_in_use();
    return (entries_set > 256) ? 256 : entries_set;
  endfunction

  function automatic entry_t converted_pixel(logic [IdxW-1:0] idx, entry_t pix);
    entry_t p;
    entry_t res;
    logic   four_byte;
    logic   swap;
    p         = pix;
    four_byte = 1'b1;
    if (src_mode == SRC_INDEXED) begin
      p = (idx < entries_in_use()) ? color_table[idx] : '0;
    end else if (src_mode == SRC_RGB24) begin
      p.alpha   = '0;
      four_byte = 1'b0;
    end
    // Red and blue trade places whenever the byte count of the pixel changes.
    swap      = (four_byte != dst_mode);
    res.red   = swap ? p.blue : p.red;
    res.green = p.green;
    res.blue  = swap ? p.red : p.blue;
    if (dst_mode == DST_RGB24) begin
      res.alpha = '0;
    end else begin
      res.alpha = four_byte ? p.alpha : ChanMax;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    $display("%0t palette_pixel_checker: %s got %0d expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [IdxW-1:0] idx;
    entry_t          pix;
    entry_t          got;
    entry_t          want;
    int unsigned     n;
    int unsigned     v;
    if (!rst_ni) begin
      src_mode    = SRC_INDEXED;
      dst_mode    = DST_RGBA32;
      entries_set = 9'd256;
      pixels_due.delete();
      pending_o    <= 0;
      mismatches_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SRC_FMT:   src_mode = cfg_data_i[1:0];
          CFG_DST_FMT:   dst_mode = cfg_data_i[0];
          CFG_PAL_COUNT: entries_set = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        idx = in_data_i[7:0];
        pix = {in_data_i[39:32], in_data_i[15:8], in_data_i[23:16], in_data_i[31:24]};
        n   = entries_in_use();
        case (in_user_i)
          OP_PIXEL: pixels_due.push_back(converted_pixel(idx, pix));
          OP_WR_ENTRY: begin
            if (idx < n) color_table[idx] = pix;
          end
          OP_WR_COLOR: begin
            if (idx < n) begin
              color_table[idx]       = pix;
              color_table[idx].alpha = ChanMax;
            end
          end
          OP_WR_ALPHA: begin
            if (idx < n) color_table[idx].alpha = pix.alpha;
          end
          OP_GREY_FILL: begin
            for (int i = 0; i < n; i++) begin
              v = (n > 1) ? (i * 255) / (n - 1) : 0;
              color_table[i] = {ChanMax, v[7:0], v[7:0], v[7:0]};
            end
          end
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got = {out_data_i[31:24], out_data_i[7:0], out_data_i[15:8], out_data_i[23:16]};
        if (pixels_due.size() == 0) begin
          report_mismatch("result word with none expected, data", int'(out_data_i), 0);
        end else begin
          want = pixels_due.pop_front();
          if (got.red != want.red) begin
            report_mismatch("out_red", int'(got.red), int'(want.red));
          end
          if (got.green != want.green) begin
            report_mismatch("out_green", int'(got.green), int'(want.green));
          end
          if (got.blue != want.blue) begin
            report_mismatch("out_blue", int'(got.blue), int'(want.blue));
          end
          if (got.alpha != want.alpha) begin
            report_mismatch("out_alpha", int'(got.alpha), int'(want.alpha));
          end
        end
      end
      pending_o    <= pixels_due.size();
      mismatches_o <= mismatch_count;
    end
  end

endmodule

FILE: sim/tb_palette_pixel_format_converter.sv
`timescale 1ns / 1ps
// Testbench top for the palette pixel format converter: clock, reset, stimulus and verdict.
// Depends on ppfc_pkg, the converter and palette_pixel_checker.
module tb_palette_pixel_format_converter;
  import ppfc_pkg::*;

  localparam int          CycleLimit   = 500000;
  localparam int          DrainCycles  = 300;
  localparam int          Phases       = 8;
  localparam int          PhaseItems   = 182;
  localparam logic [1:0]  SrcUnused    = 2'd3;
  localparam logic [OpW-1:0] OpUnusedLow  = 3'd5;
  localparam logic [OpW-1:0] OpUnusedHigh = 3'd7;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [39:0]         s_axis_tdata = '0;
  logic [OpW-1:0]      s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [31:0]         m_axis_tdata;
  int                  pixels_pending;
  int                  mismatches;

  bit                  loaded [256];
  int unsigned         table_count = 256;
  logic [1:0]          source_mode = SRC_INDEXED;
  int                  words_sent = 0;

  palette_pixel_format_converter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  palette_pixel_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_user_i    (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .pending_o    (pixels_pending),
    .mismatches_o (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("tb_palette_pixel_format_converter: FAIL");
    $finish;
  end

  // Random back-pressure, one long hold-off early on and a stretch without stalls.
  initial begin
    int taken;
    bit held;
    taken = 0;
    held  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) taken++;
      if (!held && taken == 250) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else begin
        m_axis_tready <= (taken >= 500 && taken < 750) || ($urandom_range(99) >= 22);
      end
    end
  end

  task automatic send_word(logic [OpW-1:0] op, logic [IdxW-1:0] idx, logic [7:0] red,
                           logic [7:0] green, logic [7:0] blue, logic [7:0] alpha);
    bit steady;
    steady = (words_sent >= 700 && words_sent < 950);
    while (!steady && $urandom_range(99) < 22) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {alpha, blue, green, red, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    if ((op == OP_WR_ENTRY || op == OP_WR_COLOR) && idx < table_count) loaded[idx] = 1'b1;
    if (op == OP_GREY_FILL) begin
      for (int i = 0; i < table_count; i++) loaded[i] = 1'b1;
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pixels_pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] index, logic [CfgDataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic configure(logic [1:0] src, logic dst, int unsigned count);
    drain();
    write_register(CFG_SRC_FMT, CfgDataW'(src));
    write_register(CFG_DST_FMT, CfgDataW'(dst));
    write_register(CFG_PAL_COUNT, CfgDataW'(count));
    cfg_valid_i <= 1'b0;
    source_mode = src;
    table_count = (count > 256) ? 256 : count;
  endtask

  initial begin
    logic [1:0]      src;
    logic            dst;
    int unsigned     count;
    int              n;
    int              roll;
    logic [OpW-1:0]  op;
    logic [IdxW-1:0] idx;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(OP_WR_ENTRY, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    send_word(OP_WR_ENTRY, 8'd255, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_word(OP_WR_COLOR, 8'd1, 8'h12, 8'h34, 8'h56, 8'h00);
    send_word(OP_WR_ALPHA, 8'd1, 8'hFF, 8'hFF, 8'hFF, 8'h5A);
    send_word(OP_PIXEL, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_word(OP_PIXEL, 8'd255, 8'h00, 8'h00, 8'h00, 8'h00);
    send_word(OP_PIXEL, 8'd1, 8'hFF, 8'h00, 8'hFF, 8'h00);
    send_word(OpUnusedLow, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_word(OpUnusedHigh, 8'd255, 8'h00, 8'h00, 8'h00, 8'h00);
    send_word(OP_GREY_FILL, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    send_word(OP_PIXEL, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    send_word(OP_PIXEL, 8'd128, 8'h00, 8'h00, 8'h00, 8'h00);
    send_word(OP_PIXEL, 8'd255, 8'h00, 8'h00, 8'h00, 8'h00);

    // A single entry in use: the ramp collapses to black, everything above it reads black.
    configure(SRC_INDEXED, DST_RGB24, 1);
    send_word(OP_GREY_FILL, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    send_word(OP_PIXEL, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    send_word(OP_WR_ENTRY, 8'd5, 8'hAA, 8'h55, 8'hAA, 8'h55);
    send_word(OP_PIXEL, 8'd5, 8'h00, 8'h00, 8'h00, 8'h00);

    // No entries in use: the fill writes nothing and every lookup misses.
    configure(SRC_INDEXED, DST_RGBA32, 0);
    send_word(OP_GREY_FILL, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    send_word(OP_WR_COLOR, 8'd0, 8'h11, 8'h22, 8'h33, 8'h44);
    send_word(OP_PIXEL, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);

    for (int ph = 0; ph < Phases; ph++) begin
      case (ph)
        0: begin src = SRC_INDEXED; dst = DST_RGBA32; count = 256; end
        1: begin src = SRC_INDEXED; dst = DST_RGB24;  count = 16;  end
        2: begin src = SRC_RGB24;   dst = DST_RGBA32; count = 2;   end
        3: begin src = SRC_RGBA32;  dst = DST_RGB24;  count = 511; end
        4: begin src = SrcUnused;   dst = DST_RGBA32; count = 0;   end
        5: begin src = SRC_RGB24;   dst = DST_RGB24;  count = 255; end
        6: begin src = SRC_RGBA32;  dst = DST_RGBA32; count = 257; end
        default: begin
          src   = SRC_INDEXED;
          dst   = DST_RGBA32;
          count = $urandom_range(256, 2);
        end
      endcase
      configure(src, dst, count);
      n = 0;
      while (n < PhaseItems) begin
        roll = $urandom_range(99);
        if (table_count > 0 && $urandom_range(99) < 85) begin
          idx = IdxW'($urandom_range(table_count - 1));
        end else begin
          idx = IdxW'($urandom_range(255));
        end
        if (roll < 50) op = OP_PIXEL;
        else if (roll < 64) op = OP_WR_ENTRY;
        else if (roll < 74) op = OP_WR_COLOR;
        else if (roll < 85) op = OP_WR_ALPHA;
        else if (roll < 88) op = OP_GREY_FILL;
        else if (roll < 93) op = OpW'($urandom_range(OpUnusedHigh, OpUnusedLow));
        else op = OP_PIXEL;
        // An entry is only read, or partly rewritten, once it holds a full value.
        if ((op == OP_WR_ALPHA || (op == OP_PIXEL && source_mode == SRC_INDEXED))
            && idx < table_count && !loaded[idx]) begin
          op = OP_WR_ENTRY;
        end
        send_word(op, idx, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)));
        if (op <= OP_GREY_FILL) n++;
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("tb_palette_pixel_format_converter: PASS");
    end else begin
      $display("tb_palette_pixel_format_converter: FAIL");
    end
    $finish;
  end

endmodule
